FILE: design/sfcc_pkg.sv
// ----------------------------------------------------------------------------
// sfcc_pkg
// Shared constants, codes and the crc-8 byte step for the sensor frame checker.
// ----------------------------------------------------------------------------
`default_nettype none

package sfcc_pkg;

  localparam int unsigned FRAME_BYTES = 9;
  localparam int unsigned POS_W       = 4;
  localparam logic [POS_W-1:0] FRAME_LAST = POS_W'(FRAME_BYTES - 1);

  localparam logic [7:0] CRC_POLY = 8'h31;
  localparam logic [7:0] CRC_INIT = 8'hFF;

  // scale factors of the fixed-point conversion (result taken >> 16)
  localparam logic [17:0] TEMP_SCALE  = 18'd175000;
  localparam logic [16:0] HUM_SCALE   = 17'd100000;
  localparam logic [18:0] TEMP_OFFSET = 19'd45000;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_CO2_LOW  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CO2_HIGH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TEMP_LOW  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TEMP_HIGH = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HUM_LOW  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_HUM_HIGH = 3'd5;
  localparam int unsigned CFG_DATA_W = 18;

  // limit reset values
  localparam logic [15:0] CO2_LOW_RST   = 16'd0;
  localparam logic [15:0] CO2_HIGH_RST  = 16'd40000;
  localparam logic [17:0] TEMP_LOW_RST  = 18'h3_5038;  // -45000
  localparam logic [17:0] TEMP_HIGH_RST = 18'd130000;
  localparam logic [16:0] HUM_LOW_RST   = 17'd0;
  localparam logic [16:0] HUM_HIGH_RST  = 17'd100000;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_CRC_ERR   = 2'd1,
    STATUS_RANGE_ERR = 2'd2
  } status_e;

  // one byte through the msb-first crc-8, no reflection
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

FILE: design/sensor_frame_crc_convert_check.sv
// ----------------------------------------------------------------------------
// sensor_frame_crc_convert_check
// Checks and converts the 9-byte measurement frame (three words with crc-8).
// ----------------------------------------------------------------------------
// Takes one frame byte per beat and can accept a byte in every cycle; the
// crc-8 update of a byte is one unrolled step, so bytes never wait on it.
// After the ninth byte of a frame the co2, temperature and humidity words go
// through a three-stage pipe (frame capture, scaling multiply, range check
// into the output register), and each stage waits while the next is full.
// Frames can follow each other without gaps; with m_axis_tready held low
// the pipe still takes bytes until its stages fill. A beat with tuser set
// restarts the frame at byte 0. A raw word of zero marks its quantity as
// absent: its converted field reads zero and it is not range-checked. A crc
// mismatch in any word wins over a range error.
`default_nettype none

module sensor_frame_crc_convert_check (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // byte stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  input  wire logic        s_axis_tuser,   // [0] frame_start
  // result stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [1:0] status, [17:2] co2_ppm, [18] co2_present, [36:19] temperature_mc,
  // [37] temperature_present, [54:38] humidity_mpct, [55] humidity_present
  output logic [55:0]      m_axis_tdata,
  // configuration writes
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [sfcc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [sfcc_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  // limits
  logic [15:0] co2_low_q, co2_high_q;
  logic [17:0] temp_low_q, temp_high_q;
  logic [16:0] hum_low_q, hum_high_q;

  // frame assembly state
  logic [sfcc_pkg::POS_W-1:0] pos_q, pos_d, pos_eff;
  logic [7:0]  crc_q, crc_d, crc_base;
  logic        fail_q, fail_d, fail_base;
  logic [7:0]  hi_q;
  logic [15:0] co2_word_q, temp_word_q, hum_word_q;

  logic [1:0]  slot;
  logic [1:0]  word_sel;
  logic        in_acc;
  logic        last_byte;
  logic [15:0] word_new;

  // pipe stage 1: captured frame
  logic        s1_valid_q;
  logic [15:0] s1_co2_q, s1_temp_q, s1_hum_q;
  logic        s1_fail_q;

  // pipe stage 2: scaled values
  logic        s2_valid_q;
  logic [15:0] s2_co2_q;
  logic        s2_tp_q, s2_hp_q, s2_fail_q;
  logic [17:0] s2_tscaled_q;
  logic [16:0] s2_hscaled_q;
  logic [33:0] t_prod;
  logic [32:0] h_prod;

  // output register
  logic        out_valid_q;
  logic [55:0] out_data_q;

  logic        out_ready, s2_ready, s1_ready;

  // range check
  logic signed [18:0] t_mc;
  logic        co2_p;
  logic        co2_bad, temp_bad, hum_bad;
  sfcc_pkg::status_e status;
  logic [17:0] temp_field;
  logic [16:0] hum_field;

  assign cfg_ready_o = 1'b1;

  assign out_ready     = !out_valid_q || m_axis_tready;
  assign s2_ready      = !s2_valid_q || out_ready;
  assign s1_ready      = !s1_valid_q || s2_ready;
  assign s_axis_tready = s1_ready;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // byte position, crc and word slot of the incoming beat
  always_comb begin
    pos_eff   = s_axis_tuser ? '0 : pos_q;
    if (pos_eff > sfcc_pkg::FRAME_LAST) begin
      pos_eff = '0;
    end
    crc_base  = s_axis_tuser ? sfcc_pkg::CRC_INIT : crc_q;
    fail_base = s_axis_tuser ? 1'b0 : fail_q;
    last_byte = (pos_eff == sfcc_pkg::FRAME_LAST);
    word_new  = {hi_q, s_axis_tdata};

    case (pos_eff)
      4'd0:    begin slot = 2'd0; word_sel = 2'd0; end
      4'd1:    begin slot = 2'd1; word_sel = 2'd0; end
      4'd2:    begin slot = 2'd2; word_sel = 2'd0; end
      4'd3:    begin slot = 2'd0; word_sel = 2'd1; end
      4'd4:    begin slot = 2'd1; word_sel = 2'd1; end
      4'd5:    begin slot = 2'd2; word_sel = 2'd1; end
      4'd6:    begin slot = 2'd0; word_sel = 2'd2; end
      4'd7:    begin slot = 2'd1; word_sel = 2'd2; end
      default: begin slot = 2'd2; word_sel = 2'd2; end
    endcase

    fail_d = fail_base;
    if (slot == 2'd2) begin
      crc_d = sfcc_pkg::CRC_INIT;
      if (s_axis_tdata != crc_base) begin
        fail_d = 1'b1;
      end
    end else begin
      crc_d = sfcc_pkg::crc8_byte(crc_base, s_axis_tdata);
    end

    pos_d = last_byte ? '0 : pos_eff + 1'b1;
  end

  // scaling products
  assign t_prod = {16'd0, sfcc_pkg::TEMP_SCALE} * {18'd0, s1_temp_q};
  assign h_prod = {16'd0, sfcc_pkg::HUM_SCALE} * {17'd0, s1_hum_q};

  // range check and status on the scaled values
  always_comb begin
    co2_p    = (s2_co2_q != 16'd0);
    t_mc     = $signed({1'b0, s2_tscaled_q}) - $signed(sfcc_pkg::TEMP_OFFSET);
    co2_bad  = co2_p && ((s2_co2_q < co2_low_q) || (s2_co2_q > co2_high_q));
    temp_bad = s2_tp_q && ((t_mc < $signed({temp_low_q[17], temp_low_q}))
                        || (t_mc > $signed({temp_high_q[17], temp_high_q})));
    hum_bad  = s2_hp_q && ((s2_hscaled_q < hum_low_q) || (s2_hscaled_q > hum_high_q));
    if (s2_fail_q) begin
      status = sfcc_pkg::STATUS_CRC_ERR;
    end else if (co2_bad || temp_bad || hum_bad) begin
      status = sfcc_pkg::STATUS_RANGE_ERR;
    end else begin
      status = sfcc_pkg::STATUS_OK;
    end
    temp_field = s2_tp_q ? t_mc[17:0] : 18'd0;
    hum_field  = s2_hp_q ? s2_hscaled_q : 17'd0;
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      co2_low_q   <= sfcc_pkg::CO2_LOW_RST;
      co2_high_q  <= sfcc_pkg::CO2_HIGH_RST;
      temp_low_q  <= sfcc_pkg::TEMP_LOW_RST;
      temp_high_q <= sfcc_pkg::TEMP_HIGH_RST;
      hum_low_q   <= sfcc_pkg::HUM_LOW_RST;
      hum_high_q  <= sfcc_pkg::HUM_HIGH_RST;
      pos_q       <= '0;
      crc_q       <= sfcc_pkg::CRC_INIT;
      fail_q      <= 1'b0;
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          sfcc_pkg::REG_CO2_LOW:   co2_low_q   <= cfg_data_i[15:0];
          sfcc_pkg::REG_CO2_HIGH:  co2_high_q  <= cfg_data_i[15:0];
          sfcc_pkg::REG_TEMP_LOW:  temp_low_q  <= cfg_data_i[17:0];
          sfcc_pkg::REG_TEMP_HIGH: temp_high_q <= cfg_data_i[17:0];
          sfcc_pkg::REG_HUM_LOW:   hum_low_q   <= cfg_data_i[16:0];
          sfcc_pkg::REG_HUM_HIGH:  hum_high_q  <= cfg_data_i[16:0];
          default: ;
        endcase
      end
      if (in_acc) begin
        pos_q  <= pos_d;
        crc_q  <= last_byte ? sfcc_pkg::CRC_INIT : crc_d;
        fail_q <= last_byte ? 1'b0 : fail_d;
      end
      if (s1_ready) begin
        s1_valid_q <= in_acc && last_byte;
      end
      if (s2_ready) begin
        s2_valid_q <= s1_valid_q;
      end
      if (out_ready) begin
        out_valid_q <= s2_valid_q;
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      if (slot == 2'd0) begin
        hi_q <= s_axis_tdata;
      end
      if (slot == 2'd1) begin
        case (word_sel)
          2'd0:    co2_word_q  <= word_new;
          2'd1:    temp_word_q <= word_new;
          default: hum_word_q  <= word_new;
        endcase
      end
    end
    if (s1_ready && in_acc && last_byte) begin
      s1_co2_q  <= co2_word_q;
      s1_temp_q <= temp_word_q;
      s1_hum_q  <= hum_word_q;
      s1_fail_q <= fail_d;
    end
    if (s2_ready && s1_valid_q) begin
      s2_co2_q     <= s1_co2_q;
      s2_tp_q      <= (s1_temp_q != 16'd0);
      s2_hp_q      <= (s1_hum_q != 16'd0);
      s2_fail_q    <= s1_fail_q;
      s2_tscaled_q <= t_prod[33:16];
      s2_hscaled_q <= h_prod[32:16];
    end
    if (out_ready && s2_valid_q) begin
      out_data_q <= {s2_hp_q, hum_field, s2_tp_q, temp_field, co2_p, s2_co2_q,
                     status};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // position never runs past the last byte of a frame
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= sfcc_pkg::FRAME_LAST)
    else $error("byte position past frame end");

  // a completed frame always enters the pipe
  a_frame_capture: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && last_byte) |=> s1_valid_q)
    else $error("completed frame not captured");

  // crc and failure flag restart after the last byte
  a_crc_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && last_byte) |=> (crc_q == sfcc_pkg::CRC_INIT) && !fail_q && (pos_q == '0))
    else $error("frame state not restarted after last byte");

  // an absent temperature reads zero, not the offset
  a_temp_absent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tdata[37]) |-> (m_axis_tdata[36:19] == 18'd0))
    else $error("absent temperature not zero");

endmodule

`default_nettype wire

FILE: dv/sensor_frame_crc_convert_check_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sensor_frame_crc_convert_check_tb
// Self-checking bench for the measurement frame checker and converter.
// ----------------------------------------------------------------------------
// A few hand-built frames come first, then phases of random frames under
// different limit settings. Each phase mixes valid frames, frames with a bad
// crc byte and stray bytes with random start flags. Every accepted byte runs
// through a local frame predictor, and each result beat is compared field by
// field with the oldest predicted reading. Both stream sides idle in random
// bursts, and one phase holds the result side off long enough to back the
// block up into its byte input.
// ----------------------------------------------------------------------------

module sensor_frame_crc_convert_check_tb;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned PHASE_BYTES = 190;
  localparam int unsigned NUM_PHASES  = 6;

  typedef struct packed {
    logic               hum_present;
    logic [16:0]        hum_mpct;
    logic               temp_present;
    logic signed [17:0] temp_mc;
    logic               co2_present;
    logic [15:0]        co2_ppm;
    sfcc_pkg::status_e  status;
  } reading_t;

  typedef struct {
    logic [7:0] rx;
    logic       start;
  } frame_byte_t;

  logic clk_i;
  logic rst_ni = 1'b0;

  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = '0;
  logic        s_axis_tuser  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;
  logic        cfg_valid_i   = 1'b0;
  logic        cfg_ready_o;
  logic [sfcc_pkg::CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [sfcc_pkg::CFG_DATA_W-1:0] cfg_data_i  = '0;

  sensor_frame_crc_convert_check i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // predictor copy of the limits
  logic [15:0]        lim_co2_lo = sfcc_pkg::CO2_LOW_RST;
  logic [15:0]        lim_co2_hi = sfcc_pkg::CO2_HIGH_RST;
  logic signed [17:0] lim_t_lo   = sfcc_pkg::TEMP_LOW_RST;
  logic signed [17:0] lim_t_hi   = sfcc_pkg::TEMP_HIGH_RST;
  logic [16:0]        lim_h_lo   = sfcc_pkg::HUM_LOW_RST;
  logic [16:0]        lim_h_hi   = sfcc_pkg::HUM_HIGH_RST;

  // predictor copy of the frame state
  logic [3:0]  frame_pos = '0;
  logic [7:0]  crc_acc   = sfcc_pkg::CRC_INIT;
  logic        crc_bad   = 1'b0;
  logic [7:0]  msb_hold  = '0;
  logic [15:0] raw_word [3] = '{default: '0};

  frame_byte_t byte_q [$];
  reading_t    readings_due [$];
  frame_byte_t nxt;
  reading_t    predicted, got_r, want_r;

  // raw words that sit on the current limits, per quantity
  logic [15:0] limit_raw [3][2] = '{default: '0};

  logic        src_idle_on  = 1'b0;
  logic        sink_idle_on = 1'b0;
  logic        hold_armed   = 1'b0;
  logic        hold_done    = 1'b0;
  int unsigned hold_cnt     = 0;
  int unsigned src_gap      = 0;
  int unsigned sink_gap     = 0;
  int unsigned cycle_cnt    = 0;

  int unsigned err_cnt = 0;
  int unsigned bytes_queued = 0, bytes_taken = 0, input_stalls = 0;
  int unsigned results_seen = 0, n_ok = 0, n_crc = 0, n_range = 0;
  logic        need_start = 1'b1;

  function automatic logic [7:0] crc31_next(logic [7:0] acc, logic [7:0] data);
    logic [7:0] r;
    r = acc ^ data;
    repeat (8) r = r[7] ? ((r << 1) ^ sfcc_pkg::CRC_POLY) : (r << 1);
    return r;
  endfunction

  function automatic logic signed [17:0] conv_temp(logic [15:0] raw);
    longint p;
    p = longint'(raw) * 175000;
    return 18'((p >> 16) - 45000);
  endfunction

  function automatic logic [16:0] conv_hum(logic [15:0] raw);
    longint p;
    p = longint'(raw) * 100000;
    return 17'(p >> 16);
  endfunction

  // one byte through the frame predictor, returns 1 when a reading is due
  function automatic bit frame_step(input logic [7:0] rx, input logic start,
                                    output reading_t r);
    logic [3:0]         at;
    logic [15:0]        co2, tw, hw;
    logic signed [17:0] tc;
    logic [16:0]        hc;
    logic               off_range;
    r = '0;
    if (start) begin
      frame_pos = '0;
      crc_acc   = sfcc_pkg::CRC_INIT;
      crc_bad   = 1'b0;
    end
    at = (frame_pos > sfcc_pkg::FRAME_LAST) ? '0 : frame_pos;
    case (at % 3)
      0: begin
        msb_hold = rx;
        crc_acc  = crc31_next(crc_acc, rx);
      end
      1: begin
        raw_word[2'(at / 3)] = {msb_hold, rx};
        crc_acc = crc31_next(crc_acc, rx);
      end
      default: begin
        if (rx != crc_acc) crc_bad = 1'b1;
        crc_acc = sfcc_pkg::CRC_INIT;
      end
    endcase
    if (at != sfcc_pkg::FRAME_LAST) begin
      frame_pos = 4'(at + 1);
      return 1'b0;
    end
    co2 = raw_word[0];
    tw  = raw_word[1];
    hw  = raw_word[2];
    tc  = (tw != 0) ? conv_temp(tw) : '0;
    hc  = (hw != 0) ? conv_hum(hw) : '0;
    off_range = ((co2 != 0) && (co2 < lim_co2_lo || co2 > lim_co2_hi)) ||
                ((tw != 0) && (tc < lim_t_lo || tc > lim_t_hi)) ||
                ((hw != 0) && (hc < lim_h_lo || hc > lim_h_hi));
    r.co2_ppm      = co2;
    r.co2_present  = co2 != 0;
    r.temp_mc      = tc;
    r.temp_present = tw != 0;
    r.hum_mpct     = hc;
    r.hum_present  = hw != 0;
    r.status = crc_bad ? sfcc_pkg::STATUS_CRC_ERR
                       : (off_range ? sfcc_pkg::STATUS_RANGE_ERR : sfcc_pkg::STATUS_OK);
    frame_pos = '0;
    crc_acc   = sfcc_pkg::CRC_INIT;
    crc_bad   = 1'b0;
    return 1'b1;
  endfunction

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      err_cnt++;
    end
  endtask

  // byte driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      src_gap       <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        if (frame_step(s_axis_tdata, s_axis_tuser, predicted)) begin
          readings_due.push_back(predicted);
        end
        bytes_taken++;
      end
      if (s_axis_tvalid && !s_axis_tready) input_stalls++;
      if (!s_axis_tvalid || s_axis_tready) begin
        if (src_gap != 0) begin
          src_gap       <= src_gap - 1;
          s_axis_tvalid <= 1'b0;
        end else if (byte_q.size() == 0) begin
          s_axis_tvalid <= 1'b0;
        end else if (src_idle_on && $urandom_range(0, 11) == 0) begin
          src_gap       <= $urandom_range(0, 15);
          s_axis_tvalid <= 1'b0;
        end else begin
          nxt = byte_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= nxt.rx;
          s_axis_tuser  <= nxt.start;
        end
      end
    end
  end

  // result monitor and ready pattern
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      sink_gap      <= 0;
      hold_cnt      <= 0;
      hold_done     <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got_r = reading_t'(m_axis_tdata);
        results_seen++;
        if (readings_due.size() == 0) begin
          $error("result beat with no reading pending");
          err_cnt++;
        end else begin
          want_r = readings_due.pop_front();
          case (want_r.status)
            sfcc_pkg::STATUS_OK:      n_ok++;
            sfcc_pkg::STATUS_CRC_ERR: n_crc++;
            default:                  n_range++;
          endcase
          check_field("status", want_r.status, got_r.status);
          check_field("co2_ppm", want_r.co2_ppm, got_r.co2_ppm);
          check_field("co2_present", want_r.co2_present, got_r.co2_present);
          check_field("temperature_mc", want_r.temp_mc, got_r.temp_mc);
          check_field("temperature_present", want_r.temp_present, got_r.temp_present);
          check_field("humidity_mpct", want_r.hum_mpct, got_r.hum_mpct);
          check_field("humidity_present", want_r.hum_present, got_r.hum_present);
        end
      end
      if (hold_armed && !hold_done) begin
        // long back-pressure stretch so the pipe fills
        m_axis_tready <= 1'b0;
        hold_cnt      <= hold_cnt + 1;
        if (hold_cnt == HOLD_CYCLES - 1) hold_done <= 1'b1;
      end else if (sink_gap != 0) begin
        sink_gap      <= sink_gap - 1;
        m_axis_tready <= 1'b0;
      end else if (sink_idle_on && $urandom_range(0, 9) == 0) begin
        sink_gap      <= $urandom_range(0, 15);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("sensor_frame_crc_convert_check_tb: errors");
      $finish;
    end
  end

  task automatic push_byte(input logic [7:0] rx, input logic start);
    byte_q.push_back('{rx, start});
    bytes_queued++;
  endtask

  task automatic push_frame(input logic [15:0] w0, input logic [15:0] w1,
                            input logic [15:0] w2, input logic start, input bit bad_crc);
    logic [15:0] words [3];
    logic [7:0]  chk;
    int          bad_slot;
    words    = '{w0, w1, w2};
    bad_slot = bad_crc ? $urandom_range(0, 2) : 3;
    for (int k = 0; k < 3; k++) begin
      chk = crc31_next(crc31_next(sfcc_pkg::CRC_INIT, words[k][15:8]), words[k][7:0]);
      if (k == bad_slot) chk ^= 8'(1 << $urandom_range(0, 7));
      push_byte(words[k][15:8], start && k == 0);
      push_byte(words[k][7:0], 1'b0);
      push_byte(chk, 1'b0);
    end
    need_start = 1'b0;
  endtask

  function automatic logic [15:0] draw_word(input int q);
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return 16'hFFFF;
      2:       return 16'h0001;
      3, 4:    return 16'(limit_raw[q][$urandom_range(0, 1)] + $urandom_range(0, 2) - 1);
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic write_limit(input logic [sfcc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [17:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      sfcc_pkg::REG_CO2_LOW:   lim_co2_lo = val[15:0];
      sfcc_pkg::REG_CO2_HIGH:  lim_co2_hi = val[15:0];
      sfcc_pkg::REG_TEMP_LOW:  lim_t_lo   = val;
      sfcc_pkg::REG_TEMP_HIGH: lim_t_hi   = val;
      sfcc_pkg::REG_HUM_LOW:   lim_h_lo   = val[16:0];
      sfcc_pkg::REG_HUM_HIGH:  lim_h_hi   = val[16:0];
      default: ;
    endcase
  endtask

  task automatic set_limits(input int phase);
    logic [15:0]        c_lo, c_hi, ra, rb, ha, hb;
    logic signed [17:0] t_lo, t_hi;
    logic [16:0]        h_lo, h_hi;
    ra = 16'($urandom_range(0, 65535));
    rb = 16'($urandom_range(0, 65535));
    ha = 16'($urandom_range(0, 65535));
    hb = 16'($urandom_range(0, 65535));
    c_lo = 16'($urandom_range(0, 65535));
    c_hi = 16'($urandom_range(0, 65535));
    if (phase == 2) begin
      // single-point window on every quantity
      rb = ra;
      hb = ha;
      c_hi = c_lo;
    end
    if (ra > rb) {ra, rb} = {rb, ra};
    if (ha > hb) {ha, hb} = {hb, ha};
    if (c_lo > c_hi) {c_lo, c_hi} = {c_hi, c_lo};
    t_lo = conv_temp(ra);
    t_hi = conv_temp(rb);
    h_lo = conv_hum(ha);
    h_hi = conv_hum(hb);
    limit_raw[0] = '{c_lo, c_hi};
    limit_raw[1] = '{ra, rb};
    limit_raw[2] = '{ha, hb};
    if (phase == 0) begin
      c_lo = 16'd0;
      c_hi = 16'hFFFF;
      t_lo = -18'sd45000;
      t_hi = 18'sd130000;
      h_lo = 17'd0;
      h_hi = 17'd100000;
    end else if (phase == 1) begin
      // every window inverted at the extremes
      c_lo = 16'hFFFF;
      c_hi = 16'd0;
      t_lo = 18'sd130000;
      t_hi = -18'sd45000;
      h_lo = 17'd100000;
      h_hi = 17'd0;
    end
    write_limit(sfcc_pkg::REG_CO2_LOW, 18'(c_lo));
    write_limit(sfcc_pkg::REG_CO2_HIGH, 18'(c_hi));
    write_limit(sfcc_pkg::REG_TEMP_LOW, t_lo);
    write_limit(sfcc_pkg::REG_TEMP_HIGH, t_hi);
    write_limit(sfcc_pkg::REG_HUM_LOW, 18'(h_lo));
    write_limit(sfcc_pkg::REG_HUM_HIGH, 18'(h_hi));
  endtask

  task automatic wait_idle();
    do @(negedge clk_i);
    while (byte_q.size() != 0 || s_axis_tvalid || readings_due.size() != 0);
    // let a partial frame or the pipe drain before touching the limits
    repeat (8) @(negedge clk_i);
  endtask

  initial begin
    int unsigned phase_start;
    int          roll;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // all words absent, then a restart after stray bytes, then a bad crc
    push_frame(16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b0);
    push_byte(8'hFF, 1'b1);
    push_byte(8'h00, 1'b0);
    push_byte(8'h5A, 1'b0);
    push_frame(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0);
    push_frame(16'h0001, 16'h0001, 16'h0001, 1'b0, 1'b1);
    wait_idle();

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      set_limits(phase);
      @(posedge clk_i);
      src_idle_on  <= (phase < 4) && (phase != 1);
      sink_idle_on <= (phase < 5);
      hold_armed   <= (phase == 4);
      @(negedge clk_i);
      phase_start = bytes_queued;
      while (bytes_queued - phase_start < PHASE_BYTES) begin
        roll = $urandom_range(0, 19);
        if (roll == 0) begin
          // stray bytes, the next frame has to resync
          repeat ($urandom_range(1, 8)) begin
            push_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
          end
          need_start = 1'b1;
        end else begin
          push_frame(draw_word(0), draw_word(1), draw_word(2),
                     need_start || $urandom_range(0, 1), roll <= 2);
        end
      end
      wait_idle();
    end

    if (readings_due.size() != 0) begin
      $error("%0d readings never came out", readings_due.size());
      err_cnt++;
    end
    $display("covered %0d bytes and %0d results: %0d ok, %0d crc error, %0d out of range",
             bytes_taken, results_seen, n_ok, n_crc, n_range);
    $display("limit settings: reset plus %0d, byte input stalled for %0d cycles",
             NUM_PHASES, input_stalls);
    if (err_cnt == 0) begin
      $display("sensor_frame_crc_convert_check_tb: clean");
    end else begin
      $display("sensor_frame_crc_convert_check_tb: errors");
    end
    $finish;
  end

endmodule
